@@ hdl/bpsm_pkg.sv @@
package bpsm_pkg;

   localparam int AdcBits    = 12;
   localparam int CountWidth = 12;
   localparam int MvWidth    = 14;
   localparam int StatWidth  = 3;
   localparam int CodeWidth  = 3;
   localparam int KWidth     = 2;
   localparam int RefWidth   = 12;
   localparam int ProdWidth  = CountWidth + RefWidth + 2;
   localparam int MaskWidth  = 6;
   localparam int CsrIdxWidth = 3;
   localparam int QueueDepth = 2;
   localparam int QueuePtrWidth = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int QueueCntWidth = $clog2(QueueDepth + 1);

   localparam int CountMaskInt =
      (AdcBits >= CountWidth) ? ((1 << CountWidth) - 1) : ((1 << AdcBits) - 1);
   localparam logic [CountWidth-1:0] CountMask = CountWidth'(CountMaskInt);
   localparam logic [RefWidth-1:0]   RefMv     = RefWidth'(3300);

   localparam logic [KWidth-1:0] KOne  = 2'd0;
   localparam logic [KWidth-1:0] KTwo  = 2'd1;
   localparam logic [KWidth-1:0] KFour = 2'd2;

   localparam logic [StatWidth-1:0] StatFault    = 3'd0;
   localparam logic [StatWidth-1:0] StatCharging = 3'd2;
   localparam logic [StatWidth-1:0] StatCharged  = 3'd4;

   localparam logic [CodeWidth-1:0] EvStatus   = 3'd0;
   localparam logic [CodeWidth-1:0] EvMpuHot   = 3'd1;
   localparam logic [CodeWidth-1:0] EvCharged  = 3'd2;
   localparam logic [CodeWidth-1:0] EvCharging = 3'd3;
   localparam logic [CodeWidth-1:0] EvLiHot    = 3'd4;
   localparam logic [CodeWidth-1:0] EvFault    = 3'd5;
   localparam logic [CodeWidth-1:0] EvLow      = 3'd6;

   localparam logic [CsrIdxWidth-1:0] CsrPresent  = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CsrFloor    = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CsrPrimLow  = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CsrLiLow    = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CsrMpuHot   = 3'd4;
   localparam logic [CsrIdxWidth-1:0] CsrLiHot    = 3'd5;

   // result slots, emitted lowest first
   localparam logic [MaskWidth-1:0] SlotStatus  = 6'b000001;
   localparam logic [MaskWidth-1:0] SlotMpuHot  = 6'b000010;
   localparam logic [MaskWidth-1:0] SlotCharger = 6'b000100;
   localparam logic [MaskWidth-1:0] SlotLiHot   = 6'b001000;
   localparam logic [MaskWidth-1:0] SlotPrimLow = 6'b010000;
   localparam logic [MaskWidth-1:0] SlotLiLow   = 6'b100000;

   typedef struct packed {
      logic [MaskWidth-1:0] mask;
      logic [CodeWidth-1:0] charger_code;
      logic [MvWidth-1:0]   mpu_mv;
      logic [MvWidth-1:0]   therm_mv;
      logic [MvWidth-1:0]   li_mv;
      logic [MvWidth-1:0]   prim_mv;
      logic                 changed;
      logic                 usb;
   } rec_type;

   function automatic logic [MvWidth-1:0] to_mv(input logic [CountWidth-1:0] count,
                                                input logic [KWidth-1:0] kshift);
      logic [CountWidth-1:0] c;
      logic [ProdWidth-1:0]  p;
      c = count & CountMask;
      p = (ProdWidth'(c) * ProdWidth'(RefMv)) << kshift;
      return MvWidth'(p >> AdcBits);
   endfunction

endpackage

@@ hdl/bpsm_front.sv @@
module bpsm_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [bpsm_pkg::StatWidth-1:0]    req_charger_status,
   input  logic [bpsm_pkg::CountWidth-1:0]   req_mpu_temp_count,
   input  logic [bpsm_pkg::CountWidth-1:0]   req_backup_count,
   input  logic [bpsm_pkg::CountWidth-1:0]   req_therm_count,
   input  logic [bpsm_pkg::CountWidth-1:0]   req_lithium_count,
   input  logic [bpsm_pkg::CountWidth-1:0]   req_primary_count,
   input  logic                              csr_wr_en,
   input  logic [bpsm_pkg::CsrIdxWidth-1:0]  csr_index,
   input  logic [bpsm_pkg::MvWidth-1:0]      csr_wdata,
   input  logic                              q_full,
   output logic                              q_push,
   output bpsm_pkg::rec_type                 q_rec
);

   logic [bpsm_pkg::MvWidth-1:0] present_th_ff, floor_th_ff, prim_low_ff;
   logic [bpsm_pkg::MvWidth-1:0] li_low_ff, mpu_hot_ff, li_hot_ff;

   logic                           a_valid_ff, a_valid_in;
   logic [bpsm_pkg::StatWidth-1:0] a_stat_ff;
   logic [bpsm_pkg::MvWidth-1:0]   a_mpu_ff, a_backup_ff, a_therm_ff, a_li_ff, a_prim_ff;

   logic [bpsm_pkg::StatWidth-1:0] prev_stat_ff;
   logic                           li_was_ff, prim_was_ff, backup_was_ff, checked_ff;

   logic accept;
   logic usb, li_p, prim_p, backup_p, changed;
   logic chg_hit;
   logic [bpsm_pkg::CodeWidth-1:0] chg_code;
   logic [bpsm_pkg::MaskWidth-1:0] mask;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         present_th_ff <= bpsm_pkg::MvWidth'(2000);
         floor_th_ff   <= bpsm_pkg::MvWidth'(1000);
         prim_low_ff   <= bpsm_pkg::MvWidth'(2300);
         li_low_ff     <= bpsm_pkg::MvWidth'(3400);
         mpu_hot_ff    <= bpsm_pkg::MvWidth'(800);
         li_hot_ff     <= bpsm_pkg::MvWidth'(800);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            bpsm_pkg::CsrPresent: present_th_ff <= csr_wdata;
            bpsm_pkg::CsrFloor:   floor_th_ff   <= csr_wdata;
            bpsm_pkg::CsrPrimLow: prim_low_ff   <= csr_wdata;
            bpsm_pkg::CsrLiLow:   li_low_ff     <= csr_wdata;
            bpsm_pkg::CsrMpuHot:  mpu_hot_ff    <= csr_wdata;
            bpsm_pkg::CsrLiHot:   li_hot_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign q_push    = a_valid_ff && !q_full;
   assign req_ready = !a_valid_ff || q_push;
   assign accept    = req_valid && req_ready;

   always_comb begin
      a_valid_in = a_valid_ff;
      if (accept) begin
         a_valid_in = 1'b1;
      end else if (q_push) begin
         a_valid_in = 1'b0;
      end
   end

   // scaling stage
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
      if (accept) begin
         a_stat_ff   <= req_charger_status;
         a_mpu_ff    <= bpsm_pkg::to_mv(req_mpu_temp_count, bpsm_pkg::KOne);
         a_backup_ff <= bpsm_pkg::to_mv(req_backup_count, bpsm_pkg::KFour);
         a_therm_ff  <= bpsm_pkg::to_mv(req_therm_count, bpsm_pkg::KOne);
         a_li_ff     <= bpsm_pkg::to_mv(req_lithium_count, bpsm_pkg::KTwo);
         a_prim_ff   <= bpsm_pkg::to_mv(req_primary_count, bpsm_pkg::KTwo);
      end
   end

   // classification
   always_comb begin
      usb      = !a_stat_ff[0];
      li_p     = a_li_ff > present_th_ff;
      prim_p   = a_prim_ff > present_th_ff;
      backup_p = a_backup_ff > present_th_ff;
      changed  = !checked_ff || (a_stat_ff != prev_stat_ff) || (li_p != li_was_ff) ||
                 (prim_p != prim_was_ff) || (backup_p != backup_was_ff);
      chg_hit  = 1'b1;
      case (a_stat_ff)
         bpsm_pkg::StatCharged:  chg_code = bpsm_pkg::EvCharged;
         bpsm_pkg::StatCharging: chg_code = bpsm_pkg::EvCharging;
         bpsm_pkg::StatFault:    chg_code = bpsm_pkg::EvFault;
         default: begin
            chg_code = bpsm_pkg::EvStatus;
            chg_hit  = 1'b0;
         end
      endcase
      mask    = bpsm_pkg::SlotStatus;
      mask[1] = changed && (a_mpu_ff > mpu_hot_ff);
      mask[2] = changed && usb && chg_hit;
      mask[3] = changed && usb && (a_stat_ff == bpsm_pkg::StatCharging) &&
                (a_therm_ff > li_hot_ff);
      mask[4] = changed && !usb && (a_prim_ff > floor_th_ff) && (a_prim_ff < prim_low_ff);
      mask[5] = changed && !usb && (a_li_ff > floor_th_ff) && (a_li_ff < li_low_ff);

      q_rec.mask         = mask;
      q_rec.charger_code = chg_code;
      q_rec.mpu_mv       = a_mpu_ff;
      q_rec.therm_mv     = a_therm_ff;
      q_rec.li_mv        = a_li_ff;
      q_rec.prim_mv      = a_prim_ff;
      q_rec.changed      = changed;
      q_rec.usb          = usb;
   end

   // check history
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_stat_ff  <= '0;
         li_was_ff     <= 1'b0;
         prim_was_ff   <= 1'b0;
         backup_was_ff <= 1'b0;
         checked_ff    <= 1'b0;
      end else if (q_push) begin
         prev_stat_ff  <= a_stat_ff;
         li_was_ff     <= li_p;
         prim_was_ff   <= prim_p;
         backup_was_ff <= backup_p;
         checked_ff    <= 1'b1;
      end
   end

endmodule

@@ hdl/bpsm_queue.sv @@
module bpsm_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  bpsm_pkg::rec_type push_rec,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output bpsm_pkg::rec_type head_rec
);

   bpsm_pkg::rec_type entry_ff [bpsm_pkg::QueueDepth];
   logic [bpsm_pkg::QueuePtrWidth-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [bpsm_pkg::QueueCntWidth-1:0] count_ff;

   assign full       = (count_ff == bpsm_pkg::QueueCntWidth'(bpsm_pkg::QueueDepth));
   assign head_valid = (count_ff != '0);
   assign head_rec   = entry_ff[rd_ptr_ff];

   function automatic logic [bpsm_pkg::QueuePtrWidth-1:0] next_ptr(
      input logic [bpsm_pkg::QueuePtrWidth-1:0] p);
      if (p == bpsm_pkg::QueuePtrWidth'(bpsm_pkg::QueueDepth - 1)) begin
         return '0;
      end
      return p + bpsm_pkg::QueuePtrWidth'(1);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         if (push && !pop) begin
            count_ff <= count_ff + bpsm_pkg::QueueCntWidth'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - bpsm_pkg::QueueCntWidth'(1);
         end
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_rec;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("queue read while empty");

endmodule

@@ hdl/bpsm_back.sv @@
module bpsm_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            head_valid,
   input  bpsm_pkg::rec_type               head_rec,
   output logic                            pop,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [bpsm_pkg::CodeWidth-1:0]  rsp_event_code,
   output logic [bpsm_pkg::MvWidth-1:0]    rsp_value_mv,
   output logic                            rsp_status_changed,
   output logic                            rsp_usb_present,
   output logic                            rsp_last_result
);

   logic                           work_valid_ff, work_valid_in;
   logic [bpsm_pkg::MaskWidth-1:0] mask_ff, mask_in;
   bpsm_pkg::rec_type              work_ff;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [bpsm_pkg::CodeWidth-1:0] code_ff, code_in;
   logic [bpsm_pkg::MvWidth-1:0]   value_ff, value_in;
   logic                           changed_ff, usb_ff, last_ff;

   logic                           out_free, advance, last;
   logic [bpsm_pkg::MaskWidth-1:0] sel, remain;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign advance  = work_valid_ff && out_free;
   assign sel      = mask_ff & (~mask_ff + bpsm_pkg::MaskWidth'(1));
   assign remain   = mask_ff & ~sel;
   assign last     = (remain == '0);
   assign pop      = head_valid && (!work_valid_ff || (advance && last));

   always_comb begin
      work_valid_in = work_valid_ff;
      mask_in       = mask_ff;
      if (pop) begin
         work_valid_in = 1'b1;
         mask_in       = head_rec.mask;
      end else if (advance) begin
         work_valid_in = !last;
         mask_in       = remain;
      end
   end

   always_comb begin
      case (sel)
         bpsm_pkg::SlotMpuHot: begin
            code_in  = bpsm_pkg::EvMpuHot;
            value_in = work_ff.mpu_mv;
         end
         bpsm_pkg::SlotCharger: begin
            code_in  = work_ff.charger_code;
            value_in = work_ff.li_mv;
         end
         bpsm_pkg::SlotLiHot: begin
            code_in  = bpsm_pkg::EvLiHot;
            value_in = work_ff.therm_mv;
         end
         bpsm_pkg::SlotPrimLow: begin
            code_in  = bpsm_pkg::EvLow;
            value_in = work_ff.prim_mv;
         end
         bpsm_pkg::SlotLiLow: begin
            code_in  = bpsm_pkg::EvLow;
            value_in = work_ff.li_mv;
         end
         default: begin
            code_in  = bpsm_pkg::EvStatus;
            value_in = work_ff.li_mv;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_valid_ff <= 1'b0;
         mask_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         work_valid_ff <= work_valid_in;
         mask_ff       <= mask_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      if (pop) begin
         work_ff <= head_rec;
      end
      if (advance) begin
         code_ff    <= code_in;
         value_ff   <= value_in;
         changed_ff <= work_ff.changed;
         usb_ff     <= work_ff.usb;
         last_ff    <= last;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_event_code     = code_ff;
   assign rsp_value_mv       = value_ff;
   assign rsp_status_changed = changed_ff;
   assign rsp_usb_present    = usb_ff;
   assign rsp_last_result    = last_ff;

   a_work_has_slot: assert property (@(posedge clock) disable iff (reset)
      work_valid_ff |-> (mask_ff != '0))
      else $error("active check with no results left");

   a_event_needs_change: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (code_ff != bpsm_pkg::EvStatus)) |-> changed_ff)
      else $error("event result without a status change");

   a_hot_needs_usb: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (code_ff == bpsm_pkg::EvLiHot)) |-> usb_ff)
      else $error("lithium hot result without usb");

endmodule

@@ hdl/battery_power_status_monitor_top.sv @@
// Battery power status monitor. Each transfer on the req_ channel is one power check: charger
// status pins plus six ADC counts. The front stage scales the counts to millivolts, then
// compares them against the csr_ thresholds and the stored history and places the classified
// check in a two-entry queue. The back stage emits the check's results on the rsp_ channel,
// one per cycle unless rsp_ready stalls it: a status result always, then up to three events
// when the status or a presence flag changed (or on the first check); rsp_last_result marks
// the final one. A check therefore yields one to four results, and the result sequencer sets
// the sustained rate; with rsp_ready held high and one-result checks, a check is taken every
// cycle. Requests pass the scaling register, the queue and the sequencer registers. csr_ writes
// take effect at once and are meant for an idle block; indexes beyond the sixth are ignored.
module battery_power_status_monitor_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [bpsm_pkg::StatWidth-1:0]    req_charger_status,
   input  logic [bpsm_pkg::CountWidth-1:0]   req_vref_count,
   input  logic [bpsm_pkg::CountWidth-1:0]   req_mpu_temp_count,
   input  logic [bpsm_pkg::CountWidth-1:0]   req_backup_count,
   input  logic [bpsm_pkg::CountWidth-1:0]   req_therm_count,
   input  logic [bpsm_pkg::CountWidth-1:0]   req_lithium_count,
   input  logic [bpsm_pkg::CountWidth-1:0]   req_primary_count,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [bpsm_pkg::CodeWidth-1:0]    rsp_event_code,
   output logic [bpsm_pkg::MvWidth-1:0]      rsp_value_mv,
   output logic                              rsp_status_changed,
   output logic                              rsp_usb_present,
   output logic                              rsp_last_result,
   input  logic                              csr_wr_en,
   input  logic [bpsm_pkg::CsrIdxWidth-1:0]  csr_index,
   input  logic [bpsm_pkg::MvWidth-1:0]      csr_wdata
);

   logic              q_full, q_push, q_pop, q_head_valid;
   bpsm_pkg::rec_type q_push_rec, q_head_rec;

   // reference count carries no information for any result
   logic vref_unused;
   assign vref_unused = ^req_vref_count;

   bpsm_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_charger_status (req_charger_status),
      .req_mpu_temp_count (req_mpu_temp_count),
      .req_backup_count   (req_backup_count),
      .req_therm_count    (req_therm_count),
      .req_lithium_count  (req_lithium_count),
      .req_primary_count  (req_primary_count),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .q_full             (q_full),
      .q_push             (q_push),
      .q_rec              (q_push_rec)
   );

   bpsm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_rec   (q_push_rec),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_rec   (q_head_rec)
   );

   bpsm_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head_valid         (q_head_valid),
      .head_rec           (q_head_rec),
      .pop                (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_event_code     (rsp_event_code),
      .rsp_value_mv       (rsp_value_mv),
      .rsp_status_changed (rsp_status_changed),
      .rsp_usb_present    (rsp_usb_present),
      .rsp_last_result    (rsp_last_result)
   );

endmodule

@@ verif/tb_battery_power_status_monitor_top.sv @@
`timescale 1ns / 1ps
module tb_battery_power_status_monitor_top;
   import bpsm_pkg::*;

   localparam int CycleLimit = 200000;
   localparam int NumDirected = 20;
   localparam int NumPhases = 6;
   localparam int ChecksPerPhase = 80;
   localparam int DrainCycles = 10;
   localparam int unsigned AdcFullScaleMv = 3300;

   localparam logic [StatWidth-1:0] StatUnplugIdle  = 3'd1;
   localparam logic [StatWidth-1:0] StatLow         = 3'd3;
   localparam logic [StatWidth-1:0] StatUnplugStat1 = 3'd5;
   localparam logic [StatWidth-1:0] StatNoLi        = 3'd6;
   localparam logic [StatWidth-1:0] StatNoUsb       = 3'd7;

   localparam logic [CsrIdxWidth-1:0] CsrSpare6 = 3'd6;
   localparam logic [CsrIdxWidth-1:0] CsrSpare7 = 3'd7;

   typedef struct packed {
      logic [StatWidth-1:0]  stat;
      logic [CountWidth-1:0] vref;
      logic [CountWidth-1:0] mpu;
      logic [CountWidth-1:0] backup;
      logic [CountWidth-1:0] therm;
      logic [CountWidth-1:0] li;
      logic [CountWidth-1:0] prim;
   } check_t;

   typedef struct packed {
      logic [CodeWidth-1:0] code;
      logic [MvWidth-1:0]   mv;
      logic                 changed;
      logic                 usb;
      logic                 is_last;
   } result_t;

   typedef struct packed {
      check_t            chk;
      logic [1:0]        n_typed;
      result_t [0:2]     typed;
   } dir_row_t;

   typedef logic [0:5][MvWidth-1:0] thr_set_t;

   typedef enum logic [1:0] {ReadyAlways, ReadyCoin, ReadyPeriodic, ReadySlow} ready_mode_t;

   localparam result_t NoRes = '0;
   localparam thr_set_t ResetThr = {14'd2000, 14'd1000, 14'd2300, 14'd3400, 14'd800, 14'd800};

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [StatWidth-1:0]   req_charger_status = '0;
   logic [CountWidth-1:0]  req_vref_count = '0;
   logic [CountWidth-1:0]  req_mpu_temp_count = '0;
   logic [CountWidth-1:0]  req_backup_count = '0;
   logic [CountWidth-1:0]  req_therm_count = '0;
   logic [CountWidth-1:0]  req_lithium_count = '0;
   logic [CountWidth-1:0]  req_primary_count = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b1;
   logic [CodeWidth-1:0]   rsp_event_code;
   logic [MvWidth-1:0]     rsp_value_mv;
   logic                   rsp_status_changed;
   logic                   rsp_usb_present;
   logic                   rsp_last_result;
   logic                   csr_wr_en = 1'b0;
   logic [CsrIdxWidth-1:0] csr_index = '0;
   logic [MvWidth-1:0]     csr_wdata = '0;

   // predictor state
   thr_set_t             thr = ResetThr;
   logic [StatWidth-1:0] last_stat = '0;
   logic                 li_seen = 1'b0;
   logic                 prim_seen = 1'b0;
   logic                 backup_seen = 1'b0;
   logic                 checked_once = 1'b0;

   result_t     awaited_events [$];
   result_t     head;
   dir_row_t    directed_checks [NumDirected];
   bit          failed = 1'b0;
   int          burst_left = 0;
   int unsigned cycles = 0;
   int unsigned mode_left = 0;
   int unsigned tick = 0;
   ready_mode_t ready_mode = ReadyAlways;

   battery_power_status_monitor_top uut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [MvWidth-1:0] scale_count(input logic [CountWidth-1:0] count,
                                                      input int unsigned mult);
      logic [31:0] used;
      logic [31:0] prod;
      used = 32'(count) & ((32'd1 << AdcBits) - 32'd1);
      prod = used * mult * AdcFullScaleMv;
      return MvWidth'(prod >> AdcBits);
   endfunction

   function automatic int predict_power_check(input check_t c, output result_t [0:3] res);
      logic [MvWidth-1:0] mpu_mv, backup_mv, therm_mv, li_mv, prim_mv;
      logic usb, li_on, prim_on, backup_on, changed;
      int n;
      mpu_mv = scale_count(c.mpu, 1);
      backup_mv = scale_count(c.backup, 4);
      therm_mv = scale_count(c.therm, 1);
      li_mv = scale_count(c.li, 2);
      prim_mv = scale_count(c.prim, 2);
      usb = !c.stat[0];
      li_on = li_mv > thr[CsrPresent];
      prim_on = prim_mv > thr[CsrPresent];
      backup_on = backup_mv > thr[CsrPresent];
      changed = !checked_once || c.stat != last_stat || li_on != li_seen ||
                prim_on != prim_seen || backup_on != backup_seen;
      last_stat = c.stat;
      li_seen = li_on;
      prim_seen = prim_on;
      backup_seen = backup_on;
      checked_once = 1'b1;
      res = '0;
      res[0] = '{EvStatus, li_mv, changed, usb, 1'b0};
      n = 1;
      if (changed) begin
         if (mpu_mv > thr[CsrMpuHot]) begin
            res[n] = '{EvMpuHot, mpu_mv, changed, usb, 1'b0};
            n++;
         end
         if (usb) begin
            if (c.stat == StatCharged) begin
               res[n] = '{EvCharged, li_mv, changed, usb, 1'b0};
               n++;
            end else if (c.stat == StatCharging) begin
               res[n] = '{EvCharging, li_mv, changed, usb, 1'b0};
               n++;
               if (therm_mv > thr[CsrLiHot]) begin
                  res[n] = '{EvLiHot, therm_mv, changed, usb, 1'b0};
                  n++;
               end
            end else if (c.stat == StatFault) begin
               res[n] = '{EvFault, li_mv, changed, usb, 1'b0};
               n++;
            end
         end else begin
            if (prim_mv > thr[CsrFloor] && prim_mv < thr[CsrPrimLow]) begin
               res[n] = '{EvLow, prim_mv, changed, usb, 1'b0};
               n++;
            end
            if (li_mv > thr[CsrFloor] && li_mv < thr[CsrLiLow]) begin
               res[n] = '{EvLow, li_mv, changed, usb, 1'b0};
               n++;
            end
         end
      end
      res[n-1].is_last = 1'b1;
      return n;
   endfunction

   function automatic logic [CountWidth-1:0] random_count();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2, 3: return CountWidth'($urandom_range(400, 2300));
         default: return CountWidth'($urandom);
      endcase
   endfunction

   function automatic check_t random_check(input check_t prev);
      check_t c;
      c = prev;
      // a repeat with a new reference count should not count as a change
      if ($urandom_range(0, 9) < 3) begin
         c.vref = CountWidth'($urandom);
         return c;
      end
      if ($urandom_range(0, 1) == 0) c.stat = StatWidth'($urandom);
      c.vref = random_count();
      c.mpu = random_count();
      c.backup = random_count();
      c.therm = random_count();
      c.li = random_count();
      c.prim = random_count();
      return c;
   endfunction

   task automatic run_power_check(input dir_row_t row);
      result_t [0:3] res;
      int n;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_charger_status <= row.chk.stat;
      req_vref_count <= row.chk.vref;
      req_mpu_temp_count <= row.chk.mpu;
      req_backup_count <= row.chk.backup;
      req_therm_count <= row.chk.therm;
      req_lithium_count <= row.chk.li;
      req_primary_count <= row.chk.prim;
      do @(posedge clock); while (!req_ready);
      n = predict_power_check(row.chk, res);
      if (row.n_typed != 0) begin
         for (int i = 0; i < row.n_typed; i++) awaited_events.push_back(row.typed[i]);
      end else begin
         for (int i = 0; i < n; i++) awaited_events.push_back(res[i]);
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (awaited_events.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic load_thresholds(input thr_set_t vals);
      for (int i = 0; i <= CsrLiHot; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= CsrIdxWidth'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
         thr[i] = vals[i];
      end
      // unused index, must leave every threshold alone
      csr_wr_en <= 1'b1;
      csr_index <= ($urandom_range(0, 1) == 0) ? CsrSpare6 : CsrSpare7;
      csr_wdata <= MvWidth'($urandom);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      dir_row_t row;
      check_t prev;
      thr_set_t vals;
      // stat, vref, mpu_temp, backup, therm, lithium, primary
      directed_checks = '{
         '{'{StatNoUsb, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0}, 2'd1,
           '{'{EvStatus, 14'd0, 1'b1, 1'b0, 1'b1}, NoRes, NoRes}},
         '{'{StatNoUsb, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0}, 2'd1,
           '{'{EvStatus, 14'd0, 1'b0, 1'b0, 1'b1}, NoRes, NoRes}},
         '{'{StatFault, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF}, 2'd3,
           '{'{EvStatus, 14'd6598, 1'b1, 1'b1, 1'b0},
             '{EvMpuHot, 14'd3299, 1'b1, 1'b1, 1'b0},
             '{EvFault, 14'd6598, 1'b1, 1'b1, 1'b1}}},
         '{'{StatFault, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF}, 2'd1,
           '{'{EvStatus, 14'd6598, 1'b0, 1'b1, 1'b1}, NoRes, NoRes}},
         '{'{StatCharging, 12'd100, 12'd2000, 12'd0, 12'd3000, 12'd2500, 12'd0}, 2'd0, '0},
         '{'{StatCharging, 12'hFFF, 12'd2000, 12'd0, 12'd3000, 12'd2500, 12'd0}, 2'd0, '0},
         '{'{StatCharging, 12'd0, 12'd200, 12'd0, 12'd500, 12'd1000, 12'd0}, 2'd0, '0},
         '{'{StatCharged, 12'd0, 12'd0, 12'd0, 12'd0, 12'd2500, 12'd0}, 2'd0, '0},
         '{'{StatNoLi, 12'd0, 12'd3000, 12'd0, 12'd0, 12'd0, 12'd0}, 2'd0, '0},
         '{'{StatLow, 12'd0, 12'd0, 12'd0, 12'd0, 12'd1500, 12'd1000}, 2'd0, '0},
         '{'{StatNoUsb, 12'd0, 12'd0, 12'd0, 12'd0, 12'd2500, 12'd1000}, 2'd0, '0},
         '{'{StatUnplugStat1, 12'd0, 12'd0, 12'd0, 12'd0, 12'd1500, 12'd2000}, 2'd0, '0},
         '{'{StatUnplugIdle, 12'd0, 12'd0, 12'd0, 12'd0, 12'd300, 12'd300}, 2'd0, '0},
         '{'{StatUnplugIdle, 12'd0, 12'd0, 12'd700, 12'd0, 12'd300, 12'd300}, 2'd0, '0},
         '{'{StatUnplugIdle, 12'd0, 12'hFFF, 12'd700, 12'd0, 12'd1300, 12'd300}, 2'd0, '0},
         '{'{StatCharging, 12'd0, 12'd0, 12'd700, 12'hFFF, 12'd1300, 12'd300}, 2'd0, '0},
         '{'{StatFault, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0}, 2'd0, '0},
         '{'{StatCharged, 12'h800, 12'h800, 12'h800, 12'h800, 12'h800, 12'h800}, 2'd0, '0},
         '{'{StatNoUsb, 12'h7FF, 12'h7FF, 12'h7FF, 12'h7FF, 12'h7FF, 12'h7FF}, 2'd0, '0},
         '{'{StatNoLi, 12'hAAA, 12'h555, 12'hAAA, 12'h555, 12'hAAA, 12'h555}, 2'd0, '0}
      };
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      for (int r = 0; r < NumDirected; r++) run_power_check(directed_checks[r]);
      prev = directed_checks[NumDirected-1].chk;
      for (int ph = 0; ph < NumPhases; ph++) begin
         wait_idle();
         case (ph)
            0: vals = '0;
            1: vals = '1;
            2: for (int i = 0; i <= CsrLiHot; i++) vals[i] = MvWidth'($urandom);
            5: vals = ResetThr;
            default: for (int i = 0; i <= CsrLiHot; i++) vals[i] = MvWidth'($urandom_range(500, 7000));
         endcase
         load_thresholds(vals);
         for (int k = 0; k < ChecksPerPhase; k++) begin
            row = '0;
            row.chk = random_check(prev);
            prev = row.chk;
            run_power_check(row);
         end
      end
      wait_idle();
      if (failed) begin
         $display("Mismatches found");
      end else begin
         $display("No mismatches found");
      end
      $finish;
   end

   // receiver back-pressure, mode chosen at random from four
   always @(posedge clock) begin
      if (mode_left == 0) begin
         mode_left <= $urandom_range(20, 200);
         ready_mode <= ready_mode_t'($urandom_range(0, 3));
      end else begin
         mode_left <= mode_left - 1;
      end
      tick <= tick + 1;
      case (ready_mode)
         ReadyAlways: rsp_ready <= 1'b1;
         ReadyCoin: rsp_ready <= 1'($urandom_range(0, 1));
         ReadyPeriodic: rsp_ready <= (tick % 4) != 0;
         default: if ($urandom_range(0, 5) == 0) rsp_ready <= !rsp_ready;
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_events.size() == 0) begin
            $error("result with none awaited: event_code %0d value_mv %0d",
                   rsp_event_code, rsp_value_mv);
            failed = 1'b1;
         end else begin
            head = awaited_events.pop_front();
            if (rsp_event_code !== head.code) begin
               $error("event_code expected %0d actual %0d", head.code, rsp_event_code);
               failed = 1'b1;
            end
            if (rsp_value_mv !== head.mv) begin
               $error("value_mv expected %0d actual %0d", head.mv, rsp_value_mv);
               failed = 1'b1;
            end
            if (rsp_status_changed !== head.changed) begin
               $error("status_changed expected %0d actual %0d", head.changed,
                      rsp_status_changed);
               failed = 1'b1;
            end
            if (rsp_usb_present !== head.usb) begin
               $error("usb_present expected %0d actual %0d", head.usb, rsp_usb_present);
               failed = 1'b1;
            end
            if (rsp_last_result !== head.is_last) begin
               $error("last_result expected %0d actual %0d", head.is_last, rsp_last_result);
               failed = 1'b1;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CycleLimit) begin
         $display("Mismatches found");
         $finish;
      end
   end

endmodule

@@ filelist.f @@
hdl/bpsm_pkg.sv
hdl/bpsm_front.sv
hdl/bpsm_queue.sv
hdl/bpsm_back.sv
hdl/battery_power_status_monitor_top.sv
verif/tb_battery_power_status_monitor_top.sv
